// ===== rtl/lcm_pkg.sv =====
// Package for the link connection manager.
// Holds state, op and register index codes, defaults and the result record.
// No dependencies.
`default_nettype none

package lcm_pkg;

    localparam int TICK_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TMO_W      = 16;
    localparam int RETRY_W    = 4;
    localparam int STATE_W    = 3;
    localparam int OP_W       = 3;
    localparam int DBM_W      = 8;

    localparam logic [STATE_W-1:0] ST_DISC  = 3'd0;
    localparam logic [STATE_W-1:0] ST_CONN  = 3'd1;
    localparam logic [STATE_W-1:0] ST_ADDR  = 3'd2;
    localparam logic [STATE_W-1:0] ST_READY = 3'd3;
    localparam logic [STATE_W-1:0] ST_RECON = 3'd4;
    localparam logic [STATE_W-1:0] ST_ERR   = 3'd5;

    localparam logic [OP_W-1:0] OP_CONNECT    = 3'd0;
    localparam logic [OP_W-1:0] OP_DISCONNECT = 3'd1;
    localparam logic [OP_W-1:0] OP_CONN_RES   = 3'd2;
    localparam logic [OP_W-1:0] OP_LINK_LOST  = 3'd3;
    localparam logic [OP_W-1:0] OP_ADDR_READY = 3'd4;
    localparam logic [OP_W-1:0] OP_TICK       = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_CONNECT_TMO   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_TMO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECONNECT_DLY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MONITOR_PER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT   = 3'd4;

    localparam logic [TMO_W-1:0]   CONNECT_TMO_RST   = 16'd15;
    localparam logic [TMO_W-1:0]   ADDRESS_TMO_RST   = 16'd60;
    localparam logic [TMO_W-1:0]   RECONNECT_DLY_RST = 16'd5;
    localparam logic [TMO_W-1:0]   MONITOR_PER_RST   = 16'd5;
    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST   = 4'd6;
    localparam logic [RETRY_W-1:0] RETRY_MAX         = 4'd15;

    typedef struct packed {
        logic [STATE_W-1:0]       link_state;
        logic [RETRY_W-1:0]       retry_count;
        logic                     issue_connect;
        logic                     issue_disconnect;
        logic                     ready_entered;
        logic                     timer_fired;
        logic                     address_valid;
        logic                     signal_valid;
        logic signed [DBM_W-1:0]  signal_level;
        logic                     snapshot_changed;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/lcm_if.sv =====
// Handshake interfaces for the link connection manager item and result channels.
// Depends on lcm_pkg.
`default_nettype none

interface lcm_in_if
    import lcm_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic                    connect_ok;
    logic                    link_up;
    logic                    address_present;
    logic                    request_accepted;
    logic signed [DBM_W-1:0] signal_dbm;

    modport source (output valid, op, connect_ok, link_up, address_present,
                    request_accepted, signal_dbm, input ready);
    modport sink   (input valid, op, connect_ok, link_up, address_present,
                    request_accepted, signal_dbm, output ready);
endinterface

interface lcm_out_if
    import lcm_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [STATE_W-1:0]      link_state;
    logic [RETRY_W-1:0]      retry_count;
    logic                    issue_connect;
    logic                    issue_disconnect;
    logic                    ready_entered;
    logic                    timer_fired;
    logic                    address_valid;
    logic                    signal_valid;
    logic signed [DBM_W-1:0] signal_level;
    logic                    snapshot_changed;

    modport source (output valid, link_state, retry_count, issue_connect,
                    issue_disconnect, ready_entered, timer_fired, address_valid,
                    signal_valid, signal_level, snapshot_changed, input ready);
    modport sink   (input valid, link_state, retry_count, issue_connect,
                    issue_disconnect, ready_entered, timer_fired, address_valid,
                    signal_valid, signal_level, snapshot_changed, output ready);
endinterface

`default_nettype wire

// ===== rtl/link_connection_manager_fsm.sv =====
// Link connection manager: six-state link FSM with retry count, tick timeout and snapshot.
// Depends on lcm_pkg and the lcm_in_if / lcm_out_if interfaces.
//
// Usage:
//   i_item carries one transaction per command, link event or tick; o_result
//   returns exactly one result transaction per accepted item, in order.
//   Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while idle;
//   indexes beyond the register list are ignored.
//   Pipeline: two register stages; o_result.valid rises when an item moves from
//   the input register, through the FSM update, into the result register.
//   Throughput: one item per cycle while o_result is not stalled; the state/counter
//   update between the input and result registers is combinational.
//   Reset (synchronous, active low) returns the FSM to disconnected, clears
//   retries, tick counter and snapshot, loads register defaults and empties
//   both pipeline registers.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more transaction, then i_item.ready drops until the
//   result is taken.
`default_nettype none

module link_connection_manager_fsm
    import lcm_pkg::*;
#(
    parameter int TICK_BITS = TICK_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    lcm_in_if.sink                i_item,
    lcm_out_if.source             o_result
);

    localparam int CMP_W = (TICK_BITS > TMO_W) ? TICK_BITS : TMO_W;

    logic [TMO_W-1:0]   r_connect_tmo, r_address_tmo, r_reconnect_dly, r_monitor_per;
    logic [RETRY_W-1:0] r_retry_limit;

    logic                    r_in_valid;
    logic [OP_W-1:0]         r_op;
    logic                    r_ok, r_link, r_addr, r_acc;
    logic signed [DBM_W-1:0] r_dbm;

    logic                    r_out_valid;
    t_result                 r_res;

    logic [STATE_W-1:0]      r_state;
    logic [RETRY_W-1:0]      r_retries;
    logic [TICK_BITS-1:0]    r_elapsed;
    logic                    r_snap_av, r_snap_sv;
    logic signed [DBM_W-1:0] r_snap_sig;

    logic                    n_state_en;
    logic [STATE_W-1:0]      n_state;
    logic [RETRY_W-1:0]      n_retries;
    logic [TICK_BITS-1:0]    n_elapsed;
    logic                    n_snap_av, n_snap_sv;
    logic signed [DBM_W-1:0] n_snap_sig;
    t_result                 n_res;

    logic advance;
    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || advance;
    assign n_state_en   = advance;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_connect_tmo   <= CONNECT_TMO_RST;
            r_address_tmo   <= ADDRESS_TMO_RST;
            r_reconnect_dly <= RECONNECT_DLY_RST;
            r_monitor_per   <= MONITOR_PER_RST;
            r_retry_limit   <= RETRY_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CONNECT_TMO:   r_connect_tmo   <= i_cfg_data;
                REG_ADDRESS_TMO:   r_address_tmo   <= i_cfg_data;
                REG_RECONNECT_DLY: r_reconnect_dly <= i_cfg_data;
                REG_MONITOR_PER:   r_monitor_per   <= i_cfg_data;
                REG_RETRY_LIMIT:   r_retry_limit   <= i_cfg_data[RETRY_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_op   <= i_item.op;
            r_ok   <= i_item.connect_ok;
            r_link <= i_item.link_up;
            r_addr <= i_item.address_present;
            r_acc  <= i_item.request_accepted;
            r_dbm  <= i_item.signal_dbm;
        end
    end

    // next state
    always_comb begin
        logic                 timed;
        logic [TMO_W-1:0]     limit;
        logic [TICK_BITS:0]   inc;
        logic [TICK_BITS-1:0] sat;
        logic                 ev_valid;
        logic [OP_W-1:0]      ev;
        logic                 fired;
        logic [RETRY_W-1:0]   ret_inc;
        logic                 fail, fail_move;
        logic                 enter;
        logic [STATE_W-1:0]   tgt;
        logic                 refresh;
        logic                 conn_p, disc_p;

        timed     = 1'b1;
        limit     = r_connect_tmo;
        unique case (r_state)
            ST_CONN:  limit = r_connect_tmo;
            ST_ADDR:  limit = r_address_tmo;
            ST_RECON: limit = r_reconnect_dly;
            ST_READY: limit = r_monitor_per;
            default:  timed = 1'b0;
        endcase

        inc = {1'b0, r_elapsed} + {{TICK_BITS{1'b0}}, 1'b1};
        sat = inc[TICK_BITS] ? {TICK_BITS{1'b1}} : inc[TICK_BITS-1:0];

        ev_valid  = 1'b0;
        ev        = r_op;
        fired     = 1'b0;
        n_elapsed = r_elapsed;
        if (r_op == OP_TICK) begin
            if (timed) begin
                if (CMP_W'(sat) >= CMP_W'(limit)) begin
                    fired     = 1'b1;
                    ev_valid  = 1'b1;
                    n_elapsed = '0;
                end else begin
                    n_elapsed = sat;
                end
            end
        end else if (r_op <= OP_ADDR_READY) begin
            ev_valid  = 1'b1;
            n_elapsed = '0;
        end

        ret_inc   = (r_retries < RETRY_MAX) ? r_retries + RETRY_W'(1) : r_retries;
        fail      = 1'b0;
        fail_move = 1'b0;
        enter     = 1'b0;
        tgt       = r_state;
        refresh   = 1'b0;
        conn_p    = 1'b0;
        disc_p    = 1'b0;
        n_retries = r_retries;

        if (ev_valid) begin
            unique case (r_state)
                ST_DISC: begin
                    if (ev == OP_CONNECT) begin
                        conn_p = 1'b1;
                        enter  = 1'b1;
                        tgt    = ST_CONN;
                    end
                end
                ST_CONN: begin
                    case (ev)
                        OP_ADDR_READY: begin
                            n_retries = '0;
                            enter     = 1'b1;
                            tgt       = ST_READY;
                            refresh   = 1'b1;
                        end
                        OP_CONN_RES: begin
                            if (r_ok) begin
                                enter = 1'b1;
                                tgt   = ST_ADDR;
                            end else begin
                                fail      = 1'b1;
                                fail_move = 1'b1;
                            end
                        end
                        OP_DISCONNECT: begin
                            disc_p    = 1'b1;
                            n_retries = '0;
                            enter     = 1'b1;
                            tgt       = ST_DISC;
                        end
                        OP_TICK: begin
                            fail      = 1'b1;
                            fail_move = 1'b1;
                        end
                        default: ;
                    endcase
                end
                ST_ADDR: begin
                    case (ev)
                        OP_ADDR_READY: begin
                            n_retries = '0;
                            enter     = 1'b1;
                            tgt       = ST_READY;
                            refresh   = 1'b1;
                        end
                        OP_LINK_LOST: begin
                            fail      = 1'b1;
                            fail_move = 1'b1;
                        end
                        OP_DISCONNECT: begin
                            disc_p    = 1'b1;
                            n_retries = '0;
                            enter     = 1'b1;
                            tgt       = ST_DISC;
                        end
                        OP_TICK: begin
                            if (r_addr) begin
                                n_retries = '0;
                                enter     = 1'b1;
                                tgt       = ST_READY;
                                refresh   = 1'b1;
                            end else begin
                                fail      = 1'b1;
                                fail_move = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_READY: begin
                    case (ev)
                        OP_LINK_LOST: begin
                            n_retries = '0;
                            enter     = 1'b1;
                            tgt       = ST_RECON;
                        end
                        OP_DISCONNECT: begin
                            disc_p    = 1'b1;
                            n_retries = '0;
                            enter     = 1'b1;
                            tgt       = ST_DISC;
                        end
                        OP_TICK: begin
                            if (!r_link) begin
                                n_retries = '0;
                                enter     = 1'b1;
                                tgt       = ST_RECON;
                            end else begin
                                refresh = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_RECON: begin
                    case (ev)
                        OP_ADDR_READY: begin
                            n_retries = '0;
                            enter     = 1'b1;
                            tgt       = ST_READY;
                            refresh   = 1'b1;
                        end
                        OP_TICK: begin
                            if (r_link) begin
                                n_retries = '0;
                                enter     = 1'b1;
                                if (r_addr) begin
                                    tgt     = ST_READY;
                                    refresh = 1'b1;
                                end else begin
                                    tgt = ST_ADDR;
                                end
                            end else begin
                                conn_p = 1'b1;
                                if (!r_acc) begin
                                    fail = 1'b1;
                                end else begin
                                    enter = 1'b1;
                                    tgt   = ST_CONN;
                                end
                            end
                        end
                        OP_DISCONNECT: begin
                            n_retries = '0;
                            enter     = 1'b1;
                            tgt       = ST_DISC;
                        end
                        default: ;
                    endcase
                end
                ST_ERR: begin
                    if (ev == OP_CONNECT) begin
                        n_retries = '0;
                        conn_p    = 1'b1;
                        enter     = 1'b1;
                        tgt       = ST_CONN;
                    end
                end
                default: ;
            endcase
        end

        if (fail) begin
            n_retries = ret_inc;
            if (ret_inc >= r_retry_limit) begin
                enter = 1'b1;
                tgt   = ST_ERR;
            end else if (fail_move) begin
                enter = 1'b1;
                tgt   = ST_RECON;
            end
        end

        n_state    = enter ? tgt : r_state;
        n_snap_av  = r_snap_av;
        n_snap_sv  = r_snap_sv;
        n_snap_sig = r_snap_sig;
        if (enter && tgt != ST_READY) begin
            n_snap_av  = 1'b0;
            n_snap_sv  = 1'b0;
            n_snap_sig = '0;
        end
        if (refresh) begin
            n_snap_av  = r_addr;
            n_snap_sv  = r_link;
            n_snap_sig = r_link ? r_dbm : '0;
        end

        n_res.link_state       = n_state;
        n_res.retry_count      = n_retries;
        n_res.issue_connect    = conn_p;
        n_res.issue_disconnect = disc_p;
        n_res.ready_entered    = enter && tgt == ST_READY && r_state != ST_READY;
        n_res.timer_fired      = fired;
        n_res.address_valid    = n_snap_av;
        n_res.signal_valid     = n_snap_sv;
        n_res.signal_level     = n_snap_sig;
        n_res.snapshot_changed = (n_state != r_state) || (n_snap_av != r_snap_av) ||
                                 (n_snap_sv != r_snap_sv) || (n_snap_sig != r_snap_sig);
    end

    // FSM state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_DISC;
            r_retries  <= '0;
            r_elapsed  <= '0;
            r_snap_av  <= 1'b0;
            r_snap_sv  <= 1'b0;
            r_snap_sig <= '0;
        end else if (n_state_en) begin
            r_state    <= n_state;
            r_retries  <= n_retries;
            r_elapsed  <= n_elapsed;
            r_snap_av  <= n_snap_av;
            r_snap_sv  <= n_snap_sv;
            r_snap_sig <= n_snap_sig;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.link_state       = r_res.link_state;
    assign o_result.retry_count      = r_res.retry_count;
    assign o_result.issue_connect    = r_res.issue_connect;
    assign o_result.issue_disconnect = r_res.issue_disconnect;
    assign o_result.ready_entered    = r_res.ready_entered;
    assign o_result.timer_fired      = r_res.timer_fired;
    assign o_result.address_valid    = r_res.address_valid;
    assign o_result.signal_valid     = r_res.signal_valid;
    assign o_result.signal_level     = r_res.signal_level;
    assign o_result.snapshot_changed = r_res.snapshot_changed;

    // assertions
    a_ready_entry_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.ready_entered) |-> (r_res.link_state == ST_READY))
        else $error("ready_entered without ready state");

    a_snapshot_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_READY) |-> (!r_snap_av && !r_snap_sv && r_snap_sig == '0))
        else $error("snapshot not cleared outside ready");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_res.issue_connect && r_res.issue_disconnect))
        else $error("connect and disconnect issued together");

    a_state_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_state) && $stable(r_retries) && $stable(r_elapsed)))
        else $error("FSM state moved without a transaction");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("pending item dropped");

endmodule

`default_nettype wire
